@@ design/assert_macros.svh @@
// Assertion helpers shared by the smoother RTL.
// Each macro expects clk and arst_n to be visible in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define GSMN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Implication checked on every rising edge, switched off while reset is low.
`define GSMN_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

@@ design/gsmn_pkg.sv @@
// ---------------------------------------------------------------------------
// gsmn_pkg
// Shared constants and types for the Gaussian row smoother and normaliser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsmn_pkg;

	localparam int MAX_ROW     = 64;
	localparam int MAX_TAPS    = 31;
	localparam int SAMPLE_BITS = 16;
	localparam int Q_DEPTH     = 2;

	localparam int CELLS_W = 7;
	localparam int RAD_W   = 4;
	localparam int POS_W   = 6;
	localparam int TAP_W   = 5;
	localparam int COEF_W  = 16;
	localparam int NORM_W  = 16;
	localparam int PROD_W  = 33;
	localparam int ACC_W   = 38;
	localparam int CFG_W   = 7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	localparam logic REG_CELLS  = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	typedef struct packed {
		logic                          command;
		logic [TAP_W-1:0]              tap_index;
		logic [COEF_W-1:0]             coefficient;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

endpackage

`default_nettype wire

@@ design/gsmn_front.sv @@
// ---------------------------------------------------------------------------
// gsmn_front
// Accepts command items and holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gsmn_front import gsmn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t in_item,
	output logic       q_valid,
	output item_t      q_item,
	input  wire logic  q_pop
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	item_t             queue_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push;

	assign busy    = (cnt_q == CNT_W'(Q_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`GSMN_IMPLY(a_pop_not_empty, q_pop, cnt_q != '0, "item popped from an empty queue")
	`GSMN_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(Q_DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

@@ design/gsmn_back.sv @@
// ---------------------------------------------------------------------------
// gsmn_back
// Stores taps and samples, filters a completed row with one MAC per cycle,
// then normalises each filtered value with a bit-serial divider (zero on a flat row).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gsmn_back import gsmn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire item_t              q_item,
	output logic                    q_pop,
	input  wire logic [CELLS_W-1:0] cells_cfg,
	input  wire logic [RAD_W-1:0]   radius_cfg,
	output logic                    strobe,
	output logic [NORM_W-1:0]       normalized,
	output logic [POS_W-1:0]        position,
	output logic                    last,
	output logic                    flat_row
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILT,
		S_DRAIN,
		S_NRD,
		S_NLD,
		S_NDIV
	} state_t;

	state_t                    state_q;
	logic [COEF_W-1:0]         taps_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] samp_mem [MAX_ROW];
	logic signed [SAMPLE_BITS-1:0] samp_rd_q;
	logic signed [ACC_W-1:0]   filt_mem [MAX_ROW];
	logic signed [ACC_W-1:0]   filt_rd_q;

	logic [CELLS_W-1:0]        count_q;
	logic [CELLS_W-1:0]        cells_q;
	logic [RAD_W-1:0]          r_q;
	logic [POS_W-1:0]          j_q;
	logic [TAP_W-1:0]          k_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   max_q;
	logic signed [ACC_W-1:0]   min_q;
	logic [ACC_W:0]            range_q;
	logic [ACC_W+1:0]          rem_q;
	logic [NORM_W:0]           quo_q;
	logic [4:0]                bit_q;
	logic                      flat_q;

	logic                      act_s1, v_s1, lastk_s1;
	logic [COEF_W-1:0]         tap_s1;
	logic [POS_W-1:0]          j_s1;
	logic                      act_s2, lastk_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [POS_W-1:0]          j_s2;

	logic [CELLS_W-1:0]        cells_eff;
	logic [CELLS_W-1:0]        count_next;
	logic signed [7:0]         x;
	logic                      x_ok;
	logic                      samp_we;
	logic signed [ACC_W-1:0]   sum;
	logic                      filt_we;
	logic [ACC_W+1:0]          range_ext;
	logic                      ge;
	logic [ACC_W+1:0]          rem_sub;
	logic [NORM_W:0]           quo_next;
	logic                      row_end;

	// Row length clamps to 1..MAX_ROW.
	always_comb begin
		if (cells_cfg == '0) begin
			cells_eff = CELLS_W'(1);
		end else if (cells_cfg > CELLS_W'(MAX_ROW)) begin
			cells_eff = CELLS_W'(MAX_ROW);
		end else begin
			cells_eff = cells_cfg;
		end
	end

	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign count_next = count_q + 1'b1;
	assign samp_we    = q_pop && (q_item.command == CMD_PUSH)
	                    && (count_q < CELLS_W'(MAX_ROW));

	// Sample position touched by tap k of output j; positions off the row weigh zero.
	assign x    = $signed({2'b00, j_q}) - $signed({4'b0000, r_q}) + $signed({3'b000, k_q});
	assign x_ok = !x[7] && (x[6:0] < cells_q);

	assign sum     = acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign filt_we = act_s2 && lastk_s2;

	assign range_ext = {1'b0, range_q};
	assign ge        = (rem_q >= range_ext);
	assign rem_sub   = ge ? (rem_q - range_ext) : rem_q;
	assign quo_next  = {quo_q[NORM_W-1:0], ge};
	assign row_end   = ({1'b0, j_q} == (cells_q - 1'b1));

	always_ff @(posedge clk) begin
		if (samp_we) begin
			samp_mem[count_q[POS_W-1:0]] <= q_item.sample;
		end
		samp_rd_q <= samp_mem[x[POS_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (filt_we) begin
			filt_mem[j_s2] <= sum;
		end
		filt_rd_q <= filt_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.command == CMD_LOAD) && (q_item.tap_index < TAP_W'(MAX_TAPS))) begin
			taps_q[q_item.tap_index] <= q_item.coefficient;
		end
	end

	// MAC pipeline: tap and sample read, product, then accumulate in the FSM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= (state_q == S_FILT);
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s1     <= x_ok;
		tap_s1   <= taps_q[k_q];
		lastk_s1 <= ({1'b0, k_q} == {1'b0, r_q, 1'b0});
		j_s1     <= j_q;
		prod_s2  <= v_s1 ? PROD_W'($signed({1'b0, tap_s1}) * samp_rd_q) : '0;
		lastk_s2 <= lastk_s1;
		j_s2     <= j_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cells_q    <= CELLS_W'(MAX_ROW);
			r_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			acc_q      <= '0;
			max_q      <= {1'b1, {(ACC_W-1){1'b0}}};
			min_q      <= {1'b0, {(ACC_W-1){1'b1}}};
			range_q    <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			bit_q      <= '0;
			flat_q     <= 1'b0;
			strobe     <= 1'b0;
			normalized <= '0;
			position   <= '0;
			last       <= 1'b0;
			flat_row   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (act_s2) begin
				if (lastk_s2) begin
					acc_q <= '0;
					if (sum > max_q) begin
						max_q <= sum;
					end
					if (sum < min_q) begin
						min_q <= sum;
					end
				end else begin
					acc_q <= sum;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop && (q_item.command == CMD_PUSH)) begin
						if (count_next >= cells_eff) begin
							count_q <= '0;
							cells_q <= cells_eff;
							r_q     <= radius_cfg;
							j_q     <= '0;
							k_q     <= '0;
							acc_q   <= '0;
							max_q   <= {1'b1, {(ACC_W-1){1'b0}}};
							min_q   <= {1'b0, {(ACC_W-1){1'b1}}};
							state_q <= S_FILT;
						end else begin
							count_q <= count_next;
						end
					end
				end
				S_FILT: begin
					if ({1'b0, k_q} == {1'b0, r_q, 1'b0}) begin
						k_q <= '0;
						if (row_end) begin
							state_q <= S_DRAIN;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!act_s1 && !act_s2) begin
						range_q <= {max_q[ACC_W-1], max_q} - {min_q[ACC_W-1], min_q};
						flat_q  <= (max_q == min_q);
						j_q     <= '0;
						state_q <= S_NRD;
					end
				end
				S_NRD: begin
					state_q <= S_NLD;
				end
				S_NLD: begin
					rem_q <= {1'b0, ({filt_rd_q[ACC_W-1], filt_rd_q}
					                 - {min_q[ACC_W-1], min_q})};
					quo_q <= '0;
					bit_q <= 5'(NORM_W);
					if (flat_q) begin
						strobe     <= 1'b1;
						normalized <= '0;
						position   <= j_q;
						last       <= row_end;
						flat_row   <= 1'b1;
						j_q        <= j_q + 1'b1;
						state_q    <= row_end ? S_IDLE : S_NRD;
					end else begin
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					// One quotient bit per cycle; the quotient tops out at 2^16.
					quo_q <= quo_next;
					rem_q <= {rem_sub[ACC_W:0], 1'b0};
					if (bit_q == '0) begin
						strobe     <= 1'b1;
						normalized <= quo_next[NORM_W] ? {NORM_W{1'b1}} : quo_next[NORM_W-1:0];
						position   <= j_q;
						last       <= row_end;
						flat_row   <= 1'b0;
						j_q        <= j_q + 1'b1;
						state_q    <= row_end ? S_IDLE : S_NRD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GSMN_IMPLY(a_flat_zero, strobe && flat_row, normalized == '0, "flat row gave a non-zero value")
	`GSMN_IMPLY(a_pop_idle, q_pop, $past(state_q) != S_NDIV || state_q == S_IDLE,
		"item taken while a row was in progress")

endmodule

`default_nettype wire

@@ design/gaussian_smooth_minmax_normalize.sv @@
// ---------------------------------------------------------------------------
// gaussian_smooth_minmax_normalize
// Gaussian FIR row smoother with min-max normalisation to unsigned Q0.16.
// ---------------------------------------------------------------------------
// Items are taken whenever busy is low; busy rises only when the two-entry
// item queue is full. A load or a sample push that does not end a row leaves
// the queue as soon as the back end is idle. A push that ends a row of N samples
// with radius r starts an evaluation: filtering runs one multiply-accumulate
// per cycle, then the MAC pipeline drains, and each result comes from a
// bit-serial divider (a flat row skips the divider and gives zero).
// Results appear for one cycle each with strobe high and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_smooth_minmax_normalize import gsmn_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          command,
	input  wire logic [TAP_W-1:0]              tap_index,
	input  wire logic [COEF_W-1:0]             coefficient,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          wr_en,
	input  wire logic                          wr_index,
	input  wire logic [CFG_W-1:0]              wr_data,
	output logic                               strobe,
	output logic [NORM_W-1:0]                  normalized,
	output logic [POS_W-1:0]                   position,
	output logic                               last,
	output logic                               flat_row
);

	logic [CELLS_W-1:0] cells_q;
	logic [RAD_W-1:0]   radius_q;
	item_t              in_item;
	item_t              q_item;
	logic               q_valid;
	logic               q_pop;

	assign in_item.command     = command;
	assign in_item.tap_index   = tap_index;
	assign in_item.coefficient = coefficient;
	assign in_item.sample      = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q  <= CELLS_W'(64);
			radius_q <= RAD_W'(5);
		end else if (wr_en) begin
			case (wr_index)
				REG_CELLS:  cells_q  <= wr_data[CELLS_W-1:0];
				REG_RADIUS: radius_q <= wr_data[RAD_W-1:0];
				default:    cells_q  <= cells_q;
			endcase
		end
	end

	gsmn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	gsmn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.cells_cfg  (cells_q),
		.radius_cfg (radius_q),
		.strobe     (strobe),
		.normalized (normalized),
		.position   (position),
		.last       (last),
		.flat_row   (flat_row)
	);

endmodule

`default_nettype wire
